@@ hdl/brle_pkg.sv @@
// Shared types and constants for the bit run-length encoder.
package brle_pkg;

    localparam int BITS_PER_BYTE = 8;
    localparam int BIT_CNT_W     = $clog2(BITS_PER_BYTE);
    localparam int RUN_LEN_W     = 7;
    localparam logic [RUN_LEN_W-1:0] RUN_MAX = {RUN_LEN_W{1'b1}};

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [BITS_PER_BYTE-1:0] data_byte;
        logic                     last_byte;
    } q_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BITS,
        ST_FLUSH
    } eng_state_t;

endpackage

@@ hdl/brle_in_if.sv @@
// Byte input channel: valid/ready with byte and end-of-stream mark.
interface brle_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

@@ hdl/brle_out_if.sv @@
// Code output channel: valid/ready with run code and end-of-stream mark.
interface brle_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] run_code;
    logic       last_code;

    modport source (output valid, output run_code, output last_code, input ready);
    modport sink   (input valid, input run_code, input last_code, output ready);
endinterface

@@ hdl/brle_front.sv @@
// Front end: accepts input bytes into a short queue ahead of the bit engine.
module brle_front
(
    input  logic             clk,
    input  logic             rst_n,
    brle_in_if.sink          in_ch,
    output logic             q_valid,
    output brle_pkg::q_item_t q_item,
    input  logic             q_ready
);
    import brle_pkg::*;

    q_item_t            mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  cnt_reg, cnt_next;
    logic               wr_en;
    logic               rd_en;

    assign in_ch.ready = (cnt_reg != QCNT_W'(QUEUE_DEPTH));
    assign wr_en       = in_ch.valid && in_ch.ready;
    assign q_valid     = (cnt_reg != '0);
    assign rd_en       = q_valid && q_ready;
    assign q_item      = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_en ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = rd_en ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + QCNT_W'(wr_en) - QCNT_W'(rd_en);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg].data_byte <= in_ch.data_byte;
            mem_reg[wr_ptr_reg].last_byte <= in_ch.last_byte;
        end
    end

`ifndef SYNTH
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count past depth");
`endif

endmodule

@@ hdl/brle_back.sv @@
// Back end: shifts queued bytes out one bit a cycle, unless a code waits on a stalled output, and emits run codes.
module brle_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  brle_pkg::q_item_t q_item,
    output logic              q_ready,
    brle_out_if.source        out_ch
);
    import brle_pkg::*;

    eng_state_t                 state_reg, state_next;
    logic [BITS_PER_BYTE-1:0]   shift_reg;
    logic [BIT_CNT_W-1:0]       bit_cnt_reg;
    logic                       last_reg;
    logic                       run_bit_reg;
    logic [RUN_LEN_W-1:0]       run_len_reg;
    logic                       out_valid_reg;
    logic [7:0]                 out_code_reg;
    logic                       out_last_reg;

    logic bit_now;
    logic can_emit;
    logic need_emit;
    logic bit_go;
    logic flush_go;
    logic done_byte;
    logic load;
    logic emit;

    assign bit_now  = shift_reg[BITS_PER_BYTE-1];
    assign can_emit = !out_valid_reg || out_ch.ready;

    // control outputs
    always_comb
    begin
        need_emit = 1'b0;
        bit_go    = 1'b0;
        flush_go  = 1'b0;
        unique case (state_reg)
            ST_BITS:
            begin
                // close the open run on a bit change or a full run
                need_emit = (run_len_reg != '0) &&
                            ((bit_now != run_bit_reg) || (run_len_reg == RUN_MAX));
                bit_go    = !need_emit || can_emit;
            end
            ST_FLUSH:
            begin
                flush_go = can_emit;
            end
            default:
            begin
                need_emit = 1'b0;
            end
        endcase
        done_byte = bit_go && (bit_cnt_reg == BIT_CNT_W'(BITS_PER_BYTE - 1));
        load      = q_valid && ((state_reg == ST_IDLE) || (done_byte && !last_reg) || flush_go);
        emit      = (bit_go && need_emit) || flush_go;
    end

    assign q_ready = load;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (load)
                    state_next = ST_BITS;
            end
            ST_BITS:
            begin
                if (done_byte)
                begin
                    if (last_reg)
                        state_next = ST_FLUSH;
                    else
                        state_next = load ? ST_BITS : ST_IDLE;
                end
            end
            ST_FLUSH:
            begin
                if (flush_go)
                    state_next = load ? ST_BITS : ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            bit_cnt_reg   <= '0;
            last_reg      <= 1'b0;
            run_bit_reg   <= 1'b0;
            run_len_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (load)
            begin
                bit_cnt_reg <= '0;
                last_reg    <= q_item.last_byte;
            end
            else if (bit_go)
            begin
                bit_cnt_reg <= bit_cnt_reg + 1'b1;
            end

            if (bit_go)
            begin
                run_bit_reg <= bit_now;
                if ((run_len_reg == '0) || need_emit)
                    run_len_reg <= RUN_LEN_W'(1);
                else
                    run_len_reg <= run_len_reg + 1'b1;
            end
            else if (flush_go)
            begin
                // stream ends: drop back to the reset run
                run_bit_reg <= 1'b0;
                run_len_reg <= '0;
            end

            if (emit)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            shift_reg <= q_item.data_byte;
        else if (bit_go)
            shift_reg <= {shift_reg[BITS_PER_BYTE-2:0], 1'b0};

        if (emit)
        begin
            out_code_reg <= {run_bit_reg, run_len_reg};
            out_last_reg <= flush_go;
        end
    end

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.run_code  = out_code_reg;
    assign out_ch.last_code = out_last_reg;

`ifndef SYNTH
    a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> (run_len_reg != '0))
        else $error("code emitted for an empty run");

    a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> can_emit)
        else $error("code overwrites an untaken result");

    a_run_open: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_BITS) && (bit_cnt_reg != '0) |-> (run_len_reg != '0))
        else $error("no open run in mid byte");
`endif

endmodule

@@ hdl/bit_run_length_encoder_core.sv @@
// Bit run-length encoder top level: byte queue front end, serial bit engine back end.
// Throughput: one bit per cycle in the back-end engine, which loads the next byte, when one is
//   queued, as it shifts out the last bit of the current one; a byte marked last adds a flush
//   state for the final run code. Output stalls hold the engine only when it has a code to emit.
// Path: a byte is written into the queue, then loaded into the engine's shift register, and the
//   code that a bit closes is registered onto out_ch. Reset clears queue, run and output.
module bit_run_length_encoder_core
(
    input  logic       clk,
    input  logic       rst_n,
    brle_in_if.sink    in_ch,
    brle_out_if.source out_ch
);
    import brle_pkg::*;

    logic    q_valid;
    logic    q_ready;
    q_item_t q_item;

    brle_front u_front
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_ready (q_ready)
    );

    brle_back u_back
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_ready (q_ready),
        .out_ch  (out_ch)
    );

endmodule
